// ----- hw/rtl/ps2dec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2dec_pkg
// Shared types and constants of the PS/2 set 2 scan code decoder.
// ----------------------------------------------------------------------------
package ps2dec_pkg;

    localparam int KEYMAP_DEPTH_DEF = 256;

    localparam int OPC_W  = 2;
    localparam int BYTE_W = 8;
    localparam int KEY_W  = 8;
    localparam int MOD_W  = 9;
    localparam int CFG_W  = 24;
    localparam int CIDX_W = 2;

    // Number of modifiers that follow make/break; the rest are toggling locks
    localparam int NUM_HELD = 6;

    // Operation codes carried in tuser
    localparam logic [OPC_W-1:0] OP_RX_BYTE   = 2'd0;
    localparam logic [OPC_W-1:0] OP_WR_NORMAL = 2'd1;
    localparam logic [OPC_W-1:0] OP_WR_EXT    = 2'd2;

    // Prefix bytes of scan code set 2
    localparam logic [BYTE_W-1:0] BYTE_BREAK = 8'hF0;
    localparam logic [BYTE_W-1:0] BYTE_EXT   = 8'hE0;
    localparam logic [BYTE_W-1:0] BYTE_PAUSE = 8'hE1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_SHIFT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_CTRL  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ALT   = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_LOCK  = 2'd3;

    typedef struct packed {
        logic [23:0] lock_codes;
        logic [15:0] alt_codes;
        logic [15:0] ctrl_codes;
        logic [15:0] shift_codes;
    } t_cfg;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [BYTE_W-1:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic             valid;
        logic             is_press;
        logic [MOD_W-1:0] modifiers;
        logic [KEY_W-1:0] key_id;
    } t_event;

endpackage

// ----- hw/rtl/ps2_set2_scancode_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_set2_scancode_decoder
// Turns a PS/2 scan code set 2 byte stream into key events with modifiers.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  --------  ---------  --------------------------------------------------
//  s_axis    in         tuser: opcode; tdata: rx_byte, entry_index, entry_value
//  m_axis    out        tdata: key_id, modifiers, is_press
//  cfg       in         i_cfg_we / i_cfg_index / i_cfg_data, write only
//
//  Sustained rate is one beat per cycle while m_axis does not stall. The
//  accepting edge reads both keymap RAMs and the pressed bitmap at the
//  received byte (registered read); the edge that advances the input stage
//  parses prefixes, updates the bitmap and modifiers and loads the result
//  register. A bitmap write at the edge that reads the next beat is
//  forwarded to it. Reset clears parser state, modifiers and configuration;
//  then a clearing pass zeroes all KEYMAP_DEPTH (256 by default) bitmap
//  entries, with s_axis held not ready. The keymap tables keep whatever
//  they held and must be loaded before use. A stall on m_axis holds the
//  result register and the input stage; s_axis stays ready while the input
//  stage is empty or can drain into the result register.
//
module ps2_set2_scancode_decoder
    import ps2dec_pkg::*;
#(
    parameter int KEYMAP_DEPTH = KEYMAP_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,  // [7:0] rx_byte, [15:8] entry_index,
                                             // [23:16] entry_value
    input  logic [OPC_W-1:0]  s_axis_tuser,  // [1:0] opcode

    // Event stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,  // [7:0] key_id, [16:8] modifiers,
                                             // [17] is_press, [23:18] zero

    // Configuration writes
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(KEYMAP_DEPTH);

    // Configuration registers
    t_cfg   r_cfg;

    // Input stage: item plus the keymap words read at acceptance
    logic   r_a_valid;
    t_item  r_a_item;

    // Result register
    logic   r_out_valid;
    t_event r_out;

    logic             w_in_fire;
    logic             w_a_fire;
    logic             w_core_ready;
    t_item            w_in_item;
    logic [AW-1:0]    w_entry_idx;
    logic [KEY_W-1:0] w_entry_val;
    logic [KEY_W-1:0] w_norm_code;
    logic [KEY_W-1:0] w_ext_code;
    t_event           w_event;

    assign w_in_item.opcode  = s_axis_tuser;
    assign w_in_item.rx_byte = s_axis_tdata[7:0];
    assign w_entry_idx       = s_axis_tdata[8 +: AW];
    assign w_entry_val       = s_axis_tdata[23:16];

    // Advance the input stage when the result register is free or draining;
    // hold the input off until the bitmap clearing pass is done
    assign w_a_fire      = r_a_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = w_core_ready && (!r_a_valid || w_a_fire);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SHIFT: r_cfg.shift_codes <= i_cfg_data[15:0];
                CFG_CTRL:  r_cfg.ctrl_codes  <= i_cfg_data[15:0];
                CFG_ALT:   r_cfg.alt_codes   <= i_cfg_data[15:0];
                CFG_LOCK:  r_cfg.lock_codes  <= i_cfg_data;
                default:   r_cfg             <= r_cfg;
            endcase
        end
    end

    // Table writes land at acceptance, so the next beat already reads them
    ps2dec_keymap_ram #(
        .DEPTH (KEYMAP_DEPTH),
        .AW    (AW)
    ) u_normal_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_fire && (s_axis_tuser == OP_WR_NORMAL)),
        .i_waddr (w_entry_idx),
        .i_wdata (w_entry_val),
        .i_re    (w_in_fire),
        .i_raddr (w_in_item.rx_byte[AW-1:0]),
        .o_rdata (w_norm_code)
    );

    ps2dec_keymap_ram #(
        .DEPTH (KEYMAP_DEPTH),
        .AW    (AW)
    ) u_ext_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_fire && (s_axis_tuser == OP_WR_EXT)),
        .i_waddr (w_entry_idx),
        .i_wdata (w_entry_val),
        .i_re    (w_in_fire),
        .i_raddr (w_in_item.rx_byte[AW-1:0]),
        .o_rdata (w_ext_code)
    );

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_a_valid <= 1'b1;
        end else if (w_a_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_a_item <= w_in_item;
        end
    end

    ps2dec_event_core #(
        .KEYMAP_DEPTH (KEYMAP_DEPTH),
        .AW           (AW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (w_in_fire),
        .i_in_idx    (w_in_item.rx_byte[AW-1:0]),
        .o_ready     (w_core_ready),
        .i_fire      (w_a_fire),
        .i_item      (r_a_item),
        .i_norm_code (w_norm_code),
        .i_ext_code  (w_ext_code),
        .i_cfg       (r_cfg),
        .o_event     (w_event)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_a_fire) begin
            r_out_valid <= w_event.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_fire && w_event.valid) begin
            r_out <= w_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.is_press, r_out.modifiers, r_out.key_id};

endmodule

// ----- hw/rtl/ps2dec_keymap_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2dec_keymap_ram
// Key code table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ps2dec_keymap_ram
    import ps2dec_pkg::*;
#(
    parameter int DEPTH = KEYMAP_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [KEY_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [KEY_W-1:0] o_rdata
);

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ps2dec_event_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2dec_event_core
// Prefix parser, pressed-key bitmap and modifier tracking for one byte.
// ----------------------------------------------------------------------------
module ps2dec_event_core
    import ps2dec_pkg::*;
#(
    parameter int KEYMAP_DEPTH = KEYMAP_DEPTH_DEF,
    parameter int AW           = $clog2(KEYMAP_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic [AW-1:0]    i_in_idx,
    output logic             o_ready,
    input  logic             i_fire,
    input  t_item            i_item,
    input  logic [KEY_W-1:0] i_norm_code,
    input  logic [KEY_W-1:0] i_ext_code,
    input  t_cfg             i_cfg,
    output t_event           o_event
);

    typedef enum logic [4:0] {
        MODE_NORMAL    = 5'b00001,
        MODE_BREAK     = 5'b00010,
        MODE_EXT       = 5'b00100,
        MODE_EXT_BREAK = 5'b01000,
        MODE_PAUSE     = 5'b10000
    } t_mode;

    t_mode                    r_mode, n_mode;
    logic [MOD_W-1:0]         r_mods, n_mods;

    // Pressed-key bitmap: registered read at acceptance, cleared after reset
    logic             r_pr_mem [KEYMAP_DEPTH];
    logic             r_pr_rdata;
    logic             r_fwd_hit;
    logic             r_fwd_val;
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_idx;

    logic [AW-1:0]    w_idx;
    logic             w_is_rx;
    logic             w_code;
    logic             w_release;
    logic             w_ext;
    logic             w_take;
    logic             w_pr_bit;
    logic             w_pr_we;
    logic [KEY_W-1:0] w_kc;
    logic [KEY_W-1:0] w_codes [MOD_W];
    logic [MOD_W-1:0] w_hit;
    logic             w_taken;

    assign w_idx   = i_item.rx_byte[AW-1:0];
    assign w_is_rx = (i_item.opcode == OP_RX_BYTE);

    // Prefix parser
    always_comb begin
        n_mode    = r_mode;
        w_code    = 1'b0;
        w_release = 1'b0;
        w_ext     = 1'b0;
        unique case (r_mode)
            MODE_NORMAL: begin
                if (i_item.rx_byte == BYTE_BREAK) begin
                    n_mode = MODE_BREAK;
                end else if (i_item.rx_byte == BYTE_EXT) begin
                    n_mode = MODE_EXT;
                end else if (i_item.rx_byte == BYTE_PAUSE) begin
                    n_mode = MODE_PAUSE;
                end else begin
                    w_code = 1'b1;
                end
            end
            MODE_BREAK: begin
                w_code    = 1'b1;
                w_release = 1'b1;
                n_mode    = MODE_NORMAL;
            end
            MODE_EXT: begin
                if (i_item.rx_byte == BYTE_BREAK) begin
                    n_mode = MODE_EXT_BREAK;
                end else begin
                    w_code = 1'b1;
                    w_ext  = 1'b1;
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_EXT_BREAK: begin
                w_code    = 1'b1;
                w_release = 1'b1;
                w_ext     = 1'b1;
                n_mode    = MODE_NORMAL;
            end
            default: begin
                n_mode = MODE_NORMAL;
            end
        endcase
    end

    // Take the bit written at the edge that read this beat's entry
    assign w_pr_bit = r_fwd_hit ? r_fwd_val : r_pr_rdata;

    // Drop a make of a key that is already down
    assign w_take  = w_code && !(w_pr_bit && !w_release);
    assign w_pr_we = i_fire && w_is_rx && w_take;
    assign w_kc    = w_ext ? i_ext_code : i_norm_code;

    assign w_codes[0] = i_cfg.shift_codes[7:0];
    assign w_codes[1] = i_cfg.shift_codes[15:8];
    assign w_codes[2] = i_cfg.ctrl_codes[7:0];
    assign w_codes[3] = i_cfg.ctrl_codes[15:8];
    assign w_codes[4] = i_cfg.alt_codes[7:0];
    assign w_codes[5] = i_cfg.alt_codes[15:8];
    assign w_codes[6] = i_cfg.lock_codes[7:0];
    assign w_codes[7] = i_cfg.lock_codes[15:8];
    assign w_codes[8] = i_cfg.lock_codes[23:16];

    // First matching modifier wins
    always_comb begin
        w_taken = 1'b0;
        w_hit   = '0;
        for (int i = 0; i < MOD_W; i++) begin
            if (!w_taken && (w_codes[i] == w_kc)) begin
                w_hit[i] = 1'b1;
                w_taken  = 1'b1;
            end
        end
    end

    always_comb begin
        n_mods = r_mods;
        for (int i = 0; i < MOD_W; i++) begin
            if (w_hit[i]) begin
                if (i < NUM_HELD) begin
                    n_mods[i] = !w_release;
                end else if (!w_release) begin
                    n_mods[i] = !r_mods[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_mods    <= '0;
        end else if (i_fire && w_is_rx) begin
            r_mode <= n_mode;
            if (w_take) begin
                r_mods <= n_mods;
            end
        end
    end

    // Clearing pass: zero one bitmap entry per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(KEYMAP_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_ready = !r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_pr_mem[r_clr_idx] <= 1'b0;
        end else if (w_pr_we) begin
            r_pr_mem[w_idx] <= !w_release;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_pr_rdata <= r_pr_mem[i_in_idx];
            r_fwd_hit  <= w_pr_we && (w_idx == i_in_idx);
            r_fwd_val  <= !w_release;
        end
    end

    always_comb begin
        o_event.valid     = i_fire && w_is_rx && w_take;
        o_event.is_press  = !w_release;
        o_event.modifiers = n_mods;
        o_event.key_id    = w_kc;
    end

    // A byte after the pause prefix never makes an event
    a_pause_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (r_mode == MODE_PAUSE)) |-> !o_event.valid)
        else $error("event produced for byte dropped after pause prefix");

    a_repeat_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_code && !w_release && w_pr_bit) |-> !o_event.valid)
        else $error("event produced for repeated make");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in_fire)
        else $error("beat accepted during bitmap clearing");

    a_mods_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_event.valid |=> (r_mods == $past(r_mods)))
        else $error("modifiers changed without an event");

endmodule
